/* rtl/tvf_pkg.sv */
// shared widths, constants and types for the tsdf voxel fusion block
package tvf_pkg;

  localparam int unsigned IDX_W  = 15;
  localparam int unsigned DIST_W = 16;
  localparam int unsigned WGT_W  = 16;

  localparam int unsigned VOXELS_DEF     = 32768;
  localparam int unsigned DIST_FRAC_BITS = 12;

  // 1.0 in the distance format, clamped to the largest positive code
  localparam int unsigned ONE_RAW = 1 << DIST_FRAC_BITS;
  localparam logic signed [DIST_W-1:0] RESET_DIST =
    (ONE_RAW > 32767) ? 16'sh7FFF : DIST_W'(ONE_RAW);

  localparam logic [WGT_W-1:0] WEIGHT_MAX = '1;

  // one grid entry: distance and weight side by side
  typedef struct packed {
    logic signed [DIST_W-1:0] sdf;
    logic [WGT_W-1:0]         wgt;
  } voxel_word_t;

endpackage

/* rtl/tsdf_voxel_fuse.sv */
// tsdf voxel fusion: grid memory with a sequenced multiply, accumulate and serial divide
// merge mode runs each request through two shared-multiplier passes, one magnitude step
//   and 16 restoring-divide steps; keep mode and every other case skip them
// a request is taken only after the last result is written back; a held result stalls input
// reset: merge mode set, then a clearing pass writes every grid entry
//   to distance 1.0 and weight 0 before the first request is taken
module tsdf_voxel_fuse #(
  parameter int unsigned VOXELS = tvf_pkg::VOXELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tvf_pkg::IDX_W-1:0]         voxel_index_i,
  input  logic signed [tvf_pkg::DIST_W-1:0] sample_distance_i,
  input  logic [tvf_pkg::WGT_W-1:0]         sample_weight_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tvf_pkg::IDX_W-1:0]         voxel_echo_o,
  output logic signed [tvf_pkg::DIST_W-1:0] new_distance_o,
  output logic [tvf_pkg::WGT_W-1:0]         new_weight_o,
  output logic                              was_updated_o
);
  import tvf_pkg::*;

  localparam int unsigned AW = $clog2(VOXELS);
  localparam int unsigned XW = AW + IDX_W;
  localparam int unsigned PW = DIST_W + WGT_W + 1;  // one product
  localparam int unsigned SW = PW + 1;              // sum of two products
  localparam int unsigned RW = PW;                  // magnitude of the sum
  localparam int unsigned DW = WGT_W + 1;           // weight sum
  localparam int unsigned SHW = DW + DIST_W - 1;    // divisor aligned to top quotient bit
  localparam int unsigned CW = $clog2(DIST_W);

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_READ  = 9'b000000100,
    ST_EVAL  = 9'b000001000,
    ST_MUL1  = 9'b000010000,
    ST_MUL2  = 9'b000100000,
    ST_MAG   = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_FIX   = 9'b100000000
  } state_e;

  // fix hands the result to a separate write-back state; that state keeps the output
  // register handshake apart from the divide
  typedef enum logic [1:0] {
    WB_NONE = 2'b01,
    WB_PEND = 2'b10
  } wb_e;

  state_e state_q, state_d;
  wb_e    wb_q, wb_d;

  logic                     merge_mode_q;
  logic [AW-1:0]            clr_q, clr_d;
  logic [IDX_W-1:0]         idx_q;
  logic signed [DIST_W-1:0] d2_q;
  logic [WGT_W-1:0]         w2_q;
  voxel_word_t              rdata_q;
  logic signed [DIST_W-1:0] res_d_q, res_d_d;
  logic [WGT_W-1:0]         res_w_q, res_w_d;
  logic                     upd_q, upd_d;
  logic signed [SW-1:0]     acc_q, acc_d;
  logic [RW-1:0]            rem_q, rem_d;
  logic [SHW-1:0]           dsh_q, dsh_d;
  logic [DIST_W-1:0]        quo_q, quo_d;
  logic                     neg_q, neg_d;
  logic [CW-1:0]            cnt_q, cnt_d;

  logic                     out_valid_q;
  logic [IDX_W-1:0]         echo_q;
  logic signed [DIST_W-1:0] dist_out_q;
  logic [WGT_W-1:0]         wgt_out_q;
  logic                     upd_out_q;

  voxel_word_t mem [VOXELS];

  logic [XW-1:0]            idx_wide;
  logic [AW-1:0]            addr;
  logic                     in_range;
  logic                     in_fire;
  logic                     wb_fire;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  voxel_word_t              mem_wdata;

  logic [WGT_W-1:0]         mul_w;
  logic signed [DIST_W-1:0] mul_d;
  logic signed [PW-1:0]     prod;
  logic signed [SW-1:0]     neg_acc;
  logic [DW-1:0]            wsum;
  logic [DIST_W:0]          mag1, mag2;
  logic                     div_ge;

  assign idx_wide = {{AW{1'b0}}, idx_q};
  assign addr     = idx_wide[AW-1:0];
  assign in_range = idx_wide < XW'(VOXELS);

  // the next request waits until the previous write-back has left for the output
  assign in_ready_o = (state_q == ST_IDLE) & (wb_q == WB_NONE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign wb_fire    = (wb_q == WB_PEND) & (~out_valid_q | out_ready_i);

  // shared multiplier: stored pair first, then the sample pair
  assign mul_w = (state_q == ST_MUL1) ? rdata_q.wgt : w2_q;
  assign mul_d = (state_q == ST_MUL1) ? rdata_q.sdf : d2_q;
  assign prod  = $signed({1'b0, mul_w}) * mul_d;

  assign neg_acc = -acc_q;
  assign wsum    = {1'b0, rdata_q.wgt} + {1'b0, w2_q};
  assign mag1    = rdata_q.sdf[DIST_W-1] ? -{rdata_q.sdf[DIST_W-1], rdata_q.sdf}
                                         :  {rdata_q.sdf[DIST_W-1], rdata_q.sdf};
  assign mag2    = d2_q[DIST_W-1] ? -{d2_q[DIST_W-1], d2_q} : {d2_q[DIST_W-1], d2_q};
  assign div_ge  = rem_q >= {{(RW-SHW){1'b0}}, dsh_q};

  always_comb begin
    state_d = state_q;
    wb_d    = wb_q;
    clr_d   = clr_q;
    res_d_d = res_d_q;
    res_w_d = res_w_q;
    upd_d   = upd_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    if (wb_fire) begin
      wb_d = WB_NONE;
    end
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(VOXELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = ST_FIX;
        upd_d   = 1'b0;
        res_d_d = rdata_q.sdf;
        res_w_d = rdata_q.wgt;
        if (!in_range) begin
          res_d_d = RESET_DIST;
          res_w_d = '0;
        end else if (w2_q == '0) begin
          // keep stored pair, report it
        end else if (rdata_q.wgt == '0) begin
          upd_d   = 1'b1;
          res_d_d = d2_q;
          res_w_d = w2_q;
        end else if (merge_mode_q) begin
          upd_d   = 1'b1;
          res_w_d = wsum[DW-1] ? WEIGHT_MAX : wsum[WGT_W-1:0];
          state_d = ST_MUL1;
        end else begin
          upd_d = 1'b1;
          if (!(mag1 < mag2)) begin
            res_d_d = d2_q;
            res_w_d = w2_q;
          end
        end
      end
      ST_MUL1: begin
        acc_d   = {prod[PW-1], prod};
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        acc_d   = acc_q + {prod[PW-1], prod};
        state_d = ST_MAG;
      end
      ST_MAG: begin
        neg_d   = acc_q[SW-1];
        rem_d   = acc_q[SW-1] ? neg_acc[RW-1:0] : acc_q[RW-1:0];
        dsh_d   = {wsum, {(DIST_W-1){1'b0}}};
        quo_d   = '0;
        cnt_d   = CW'(DIST_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (div_ge) begin
          rem_d = rem_q - {{(RW-SHW){1'b0}}, dsh_q};
        end
        quo_d = {quo_q[DIST_W-2:0], div_ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        // from the divide, apply the sign; truncation toward zero comes for free
        if (merge_mode_q && upd_q && rdata_q.wgt != '0) begin
          res_d_d = neg_q ? -quo_q : quo_q;
        end
        if (wb_q == WB_NONE) begin
          wb_d    = WB_PEND;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // the write-back waits in place while the output register is still held
  assign mem_we    = (state_q == ST_CLEAR) | (wb_fire & upd_q);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : addr;
  always_comb begin
    mem_wdata = '{sdf: res_d_q, wgt: res_w_q};
    if (state_q == ST_CLEAR) begin
      mem_wdata = '{sdf: RESET_DIST, wgt: '0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      wb_q         <= WB_NONE;
      clr_q        <= '0;
      merge_mode_q <= 1'b1;
      out_valid_q  <= 1'b0;
      upd_q        <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q <= state_d;
      wb_q    <= wb_d;
      clr_q   <= clr_d;
      upd_q   <= upd_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        merge_mode_q <= cfg_wdata_i;
      end
      if (wb_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      idx_q <= voxel_index_i;
      d2_q  <= sample_distance_i;
      w2_q  <= sample_weight_i;
    end
    res_d_q <= res_d_d;
    res_w_q <= res_w_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    neg_q   <= neg_d;
    if (wb_fire) begin
      echo_q     <= idx_q;
      dist_out_q <= res_d_q;
      wgt_out_q  <= res_w_q;
      upd_out_q  <= upd_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign voxel_echo_o   = echo_q;
  assign new_distance_o = dist_out_q;
  assign new_weight_o   = wgt_out_q;
  assign was_updated_o  = upd_out_q;

  // a written voxel never ends up with zero weight
  a_upd_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_updated_o |-> new_weight_o != '0)
    else $error("updated voxel reports zero weight");

  // partial remainder stays below twice the aligned divisor, so no quotient bit is lost
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> {1'b0, rem_q} < {{(RW-SHW){1'b0}}, dsh_q, 1'b0})
    else $error("divide remainder out of range");

  // a new result only appears after a write-back step
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(wb_q == WB_PEND))
    else $error("result without write-back");

  // no request is taken while the grid is still being cleared
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |=> !$past(in_fire))
    else $error("request taken during clearing pass");

endmodule

/* test/tb.sv */
// self-checking testbench for the tsdf voxel fusion block
module tb;
  import tvf_pkg::*;

  localparam int unsigned GRID = VOXELS_DEF;
  localparam logic MODE_KEEP = 1'b0;
  localparam logic MODE_AVG  = 1'b1;

  typedef enum logic [1:0] {DO_SAMPLE, DO_SET_MODE, DO_SETTLE} sched_e;

  typedef struct {
    sched_e                   act;
    logic [IDX_W-1:0]         idx;
    logic signed [DIST_W-1:0] sdf;
    logic [WGT_W-1:0]         wgt;
    logic                     mode;
    bit                       calm;
  } plan_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DIST_W-1:0] sdf;
    logic [WGT_W-1:0]         wgt;
    logic                     upd;
  } voxel_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic                     cfg_wdata_i = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [IDX_W-1:0]         voxel_index_i = '0;
  logic signed [DIST_W-1:0] sample_distance_i = '0;
  logic [WGT_W-1:0]         sample_weight_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [IDX_W-1:0]         voxel_echo_o;
  logic signed [DIST_W-1:0] new_distance_o;
  logic [WGT_W-1:0]         new_weight_o;
  logic                     was_updated_o;

  tsdf_voxel_fuse u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .voxel_index_i     (voxel_index_i),
    .sample_distance_i (sample_distance_i),
    .sample_weight_i   (sample_weight_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .voxel_echo_o      (voxel_echo_o),
    .new_distance_o    (new_distance_o),
    .new_weight_o      (new_weight_o),
    .was_updated_o     (was_updated_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow grid and setting
  logic signed [DIST_W-1:0] grid_dist [GRID];
  logic [WGT_W-1:0]         grid_wgt [GRID];
  logic                     merge_avg = MODE_AVG;

  plan_t         sample_q [$];
  voxel_result_t fused_q [$];

  bit          fill_calm = 1'b0;
  bit          calm_now = 1'b0;
  bit          in_taken = 1'b0;
  int unsigned send_hold = 0;
  int unsigned sink_hold = 0;
  int          n_err = 0;
  int unsigned n_req = 0, n_skip = 0, n_first = 0, n_avg = 0, n_keep = 0, n_sat = 0;

  initial begin
    for (int i = 0; i < GRID; i++) begin
      grid_dist[i] = RESET_DIST;
      grid_wgt[i]  = '0;
    end
  end

  function automatic voxel_result_t fuse_sample(input logic [IDX_W-1:0] idx,
                                                input logic signed [DIST_W-1:0] d2,
                                                input logic [WGT_W-1:0] w2);
    voxel_result_t r;
    longint        d1l, d2l, w1l, w2l, q;
    logic [WGT_W:0] wsum;
    r.idx = idx;
    r.upd = 1'b0;
    if (idx >= GRID) begin
      r.sdf = RESET_DIST;
      r.wgt = '0;
      return r;
    end
    r.sdf = grid_dist[idx];
    r.wgt = grid_wgt[idx];
    d1l = longint'(grid_dist[idx]);
    w1l = longint'(grid_wgt[idx]);
    d2l = longint'(d2);
    w2l = longint'(w2);
    if (w2 == '0) begin
      n_skip++;
    end else begin
      r.upd = 1'b1;
      if (w1l == 0) begin
        r.sdf = d2;
        r.wgt = w2;
        n_first++;
      end else if (merge_avg == MODE_AVG) begin
        // exact weighted mean, division truncates toward zero
        q = (w1l * d1l + w2l * d2l) / (w1l + w2l);
        r.sdf = q[DIST_W-1:0];
        wsum = {1'b0, grid_wgt[idx]} + {1'b0, w2};
        r.wgt = wsum[WGT_W] ? WEIGHT_MAX : wsum[WGT_W-1:0];
        if (wsum[WGT_W]) n_sat++;
        n_avg++;
      end else begin
        // a tie in magnitude goes to the incoming sample
        if ((d1l < 0 ? -d1l : d1l) >= (d2l < 0 ? -d2l : d2l)) begin
          r.sdf = d2;
          r.wgt = w2;
        end
        n_keep++;
      end
      grid_dist[idx] = r.sdf;
      grid_wgt[idx]  = r.wgt;
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      n_err++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  task automatic queue_step(input sched_e act, input int idx, input int sdf, input int wgt,
                            input logic mode);
    plan_t p;
    p.act  = act;
    p.idx  = IDX_W'(idx);
    p.sdf  = DIST_W'(sdf);
    p.wgt  = WGT_W'(wgt);
    p.mode = mode;
    p.calm = fill_calm;
    sample_q.insert(sample_q.size(), p);
  endtask

  // sender: one request at a time, setting changes only with nothing in flight
  always @(negedge clk_i) begin : drive
    plan_t head;
    logic  go_valid;
    logic  go_we;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      go_valid = 1'b0;
      go_we    = 1'b0;
      if (send_hold != 0) begin
        send_hold--;
      end else if (sample_q.size() != 0) begin
        head = sample_q[0];
        calm_now <= head.calm;
        case (head.act)
          DO_SAMPLE: begin
            if (!head.calm && $urandom_range(0, 5) == 0) begin
              send_hold = $urandom_range(0, 3);
            end else begin
              go_valid = 1'b1;
              voxel_index_i     <= head.idx;
              sample_distance_i <= head.sdf;
              sample_weight_i   <= head.wgt;
              void'(sample_q.pop_front());
            end
          end
          DO_SET_MODE: begin
            if (fused_q.size() == 0) begin
              go_we = 1'b1;
              cfg_wdata_i <= head.mode;
              void'(sample_q.pop_front());
            end
          end
          default: begin
            if (fused_q.size() == 0) void'(sample_q.pop_front());
          end
        endcase
      end
      in_valid_i <= go_valid;
      cfg_we_i   <= go_we;
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin : sink
    if (sink_hold != 0) begin
      sink_hold--;
      out_ready_i <= 1'b0;
    end else if (!calm_now && $urandom_range(0, 4) == 0) begin
      sink_hold = $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : observe
    voxel_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) merge_avg = cfg_wdata_i;
      if (out_valid_o && out_ready_i) begin
        if (fused_q.size() == 0) begin
          n_err++;
          $display("%0t: result for voxel %0d with no request pending", $time, voxel_echo_o);
        end else begin
          want = fused_q.pop_front();
          check_field("voxel_echo", 32'(want.idx), 32'(voxel_echo_o));
          check_field("new_distance", 32'(want.sdf), 32'(new_distance_o));
          check_field("new_weight", 32'(want.wgt), 32'(new_weight_o));
          check_field("was_updated", 32'(want.upd), 32'(was_updated_o));
        end
      end
      in_taken = in_valid_i && in_ready_o;
      if (in_taken) begin
        n_req++;
        fused_q.insert(fused_q.size(),
                       fuse_sample(voxel_index_i, sample_distance_i, sample_weight_i));
      end
    end
  end

  initial begin : stimulus
    int unsigned hot [$];
    int unsigned pick;
    logic [31:0] rnd;
    int          idx_v;
    int          sdf_v;
    int          wgt_v;

    // averaging from reset: first write, saturation, rounding toward zero, skips
    queue_step(DO_SAMPLE, 0, 16'sh7FFF, 16'hFFFF, 1'b0);
    queue_step(DO_SAMPLE, 0, -16'sh8000, 16'hFFFF, 1'b0);
    queue_step(DO_SAMPLE, 0, 100, 16'h0000, 1'b0);
    queue_step(DO_SAMPLE, 15'h7FFF, -16'sh8000, 1, 1'b0);
    queue_step(DO_SAMPLE, 15'h7FFF, 16'sh7FFF, 1, 1'b0);
    queue_step(DO_SAMPLE, 15'h7FFF, -7, 3, 1'b0);
    queue_step(DO_SAMPLE, 1, 0, 16'h0000, 1'b0);
    queue_step(DO_SAMPLE, 15'h5555, 16'sh5555, 16'hAAAA, 1'b0);
    queue_step(DO_SAMPLE, 15'h2AAA, -16'sh5556, 16'h5555, 1'b0);
    queue_step(DO_SAMPLE, 15'h5555, -16'sh5556, 16'h5555, 1'b0);
    // smaller magnitude wins, ties to the sample
    queue_step(DO_SET_MODE, 0, 0, 0, MODE_KEEP);
    queue_step(DO_SAMPLE, 2, -300, 5, 1'b0);
    queue_step(DO_SAMPLE, 2, 300, 9, 1'b0);
    queue_step(DO_SAMPLE, 2, -299, 1, 1'b0);
    queue_step(DO_SAMPLE, 2, 1000, 7, 1'b0);
    queue_step(DO_SAMPLE, 2, -16'sh8000, 16'hFFFF, 1'b0);
    queue_step(DO_SAMPLE, 3, -16'sh8000, 2, 1'b0);
    queue_step(DO_SAMPLE, 3, 16'sh7FFF, 4, 1'b0);
    queue_step(DO_SAMPLE, 2, 0, 16'h0000, 1'b0);
    queue_step(DO_SAMPLE, 15'h7FFF, 0, 16'hFFFF, 1'b0);

    // random phases on a small set of hot voxels, plus scattered ones
    for (int ph = 0; ph < 8; ph++) begin
      fill_calm = (ph == 2) || (ph == 7);
      queue_step(DO_SET_MODE, 0, 0, 0, (ph % 2 == 0) ? MODE_AVG : MODE_KEEP);
      hot.delete();
      repeat ($urandom_range(4, 24)) hot.insert(hot.size(), $urandom_range(0, GRID - 1));
      for (int n = 0; n < 212; n++) begin
        if (n == 106) queue_step(DO_SETTLE, 0, 0, 0, 1'b0);
        pick = $urandom_range(0, 99);
        if (pick < 75) idx_v = int'(hot[$urandom_range(0, hot.size() - 1)]);
        else idx_v = int'($urandom_range(0, GRID - 1));
        pick = $urandom_range(0, 99);
        if (pick < 10) wgt_v = 0;
        else if (pick < 25) wgt_v = int'($urandom_range(60000, 65535));
        else if (pick < 70) wgt_v = int'($urandom_range(1, 255));
        else wgt_v = int'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        rnd = $urandom;
        if (pick < 10) begin
          case (rnd[2:0])
            3'd0:    sdf_v = -32768;
            3'd1:    sdf_v = 32767;
            3'd2:    sdf_v = 0;
            3'd3:    sdf_v = -1;
            default: sdf_v = int'(RESET_DIST);
          endcase
        end else if (pick < 25) begin
          // equal magnitudes of both signs to hit ties
          sdf_v = 1000;
          if (rnd[0]) sdf_v = -sdf_v;
        end else begin
          sdf_v = int'($signed(rnd[DIST_W-1:0]));
        end
        queue_step(DO_SAMPLE, idx_v, sdf_v, wgt_v, 1'b0);
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (sample_q.size() != 0 || fused_q.size() != 0 || in_valid_i) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("%0d samples fused under both settings: %0d averaged (%0d saturated sums),",
             n_req, n_avg, n_sat);
    $display("  %0d magnitude picks, %0d first writes, %0d zero-weight skips, %0d mismatches",
             n_keep, n_first, n_skip, n_err);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/tvf_pkg.sv
rtl/tsdf_voxel_fuse.sv
test/tb.sv
